>>> hw/rtl/fst_pkg.sv
// fst_pkg: shared types and constants for the sampler table
// holds the item layout, the action codes and the request queue sizes
// no dependencies
package fst_pkg;

    localparam int PAGE_W      = 52;
    localparam int DIST_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_LOOKUP = 1'b1
    } t_action;

    typedef logic        [PAGE_W-1:0] t_page;
    typedef logic signed [DIST_W-1:0] t_dist;

    // one classified request as the back end sees it
    typedef struct packed {
        logic  lookup;
        t_page page;
        t_dist distance;
    } t_req;

    // head of the request queue
    typedef struct packed {
        logic vld;
        t_req req;
    } t_req_q;

endpackage

>>> hw/rtl/fst_ram.sv
// fst_ram: generic simple dual port memory, one write and one registered read
// no dependencies
module fst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/fst_front.sv
// fst_front: input side of the sampler table, classifies items into a short queue
// depends on fst_pkg
module fst_front import fst_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   push,
    output logic   full,
    input  logic   i_action,
    input  t_page  i_page_number,
    input  t_dist  i_distance_in,
    output t_req_q o_head,
    input  logic   i_take
);

    t_req              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign full   = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign w_push = push && !full;
    assign w_pop  = i_take && o_head.vld;

    // classify and store an accepted transfer
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wptr].lookup   <= (i_action == ACT_LOOKUP);
            r_buf[r_wptr].page     <= i_page_number;
            r_buf[r_wptr].distance <= i_distance_in;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head.vld = (r_cnt != '0);
    assign o_head.req = r_buf[r_rptr];

    // a lone push grows the queue by exactly one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == QCNT_W'($past(r_cnt) + QCNT_W'(1))))
        else $error("request queue count did not grow on push");

endmodule

>>> hw/rtl/fst_engine.sv
// fst_engine: back end of the sampler table, sweeps the entries for match,
// free slot and oldest entry, then for an insert rewrites ages; holds the result register
// depends on fst_pkg and fst_ram
module fst_engine import fst_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_req_q i_head,
    output logic   o_take,
    output logic   empty,
    input  logic   pop,
    output logic   o_hit,
    output t_dist  o_distance_out
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int AGE_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST    = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(TABLE_ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_READ   = 6'b001000,
        S_RESULT = 6'b010000,
        S_AGE    = 6'b100000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    t_req                 r_req;
    logic [IDX_W-1:0]     r_cnt;
    logic                 r_iss;
    logic [IDX_W-1:0]     r_pidx;
    logic                 r_pv;
    logic [AGE_W-1:0]     r_fill;
    logic                 r_found;
    logic [IDX_W-1:0]     r_match_idx;
    logic                 r_free_found;
    logic [IDX_W-1:0]     r_free_idx;
    logic [AGE_W-1:0]     r_best;
    logic [IDX_W-1:0]     r_best_idx;
    logic [IDX_W-1:0]     r_slot;
    logic                 r_out_vld;
    logic                 r_out_hit;
    t_dist                r_out_dist;

    logic [PAGE_W-1:0]    w_page_rd;
    logic [DIST_W-1:0]    w_dist_rd;
    logic [AGE_W-1:0]     w_age_rd;
    logic [AGE_W-1:0]     w_aged;
    logic                 w_valid_now;
    logic                 w_hit_now;
    logic                 w_last_eval;
    logic                 w_out_free;
    logic                 w_age_we;
    logic [AGE_W-1:0]     w_age_wdata;
    logic                 w_tab_we;

    // slots fill from the bottom and never empty, so entries below the count are valid
    assign w_valid_now = (AGE_W'(r_pidx) < r_fill);
    assign w_last_eval = r_pv && (r_pidx == LAST);
    assign w_out_free  = !r_out_vld || pop;
    assign w_hit_now   = w_valid_now && (w_page_rd == r_req.page);
    assign w_aged      = (w_age_rd >= AGE_MAX) ? AGE_MAX : w_age_rd + AGE_W'(1);
    assign o_take      = (r_state == S_IDLE) && i_head.vld;

    // control sequence per request
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_head.vld) n_state = S_SCAN;
            S_SCAN:   if (w_last_eval) n_state = S_DECIDE;
            S_DECIDE: n_state = r_req.lookup ? S_READ : S_AGE;
            S_READ:   n_state = S_RESULT;
            S_RESULT: if (w_out_free) n_state = S_IDLE;
            S_AGE:    if (w_last_eval) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // entry address sweep, one entry a cycle, read data arriving in the cycle after its address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss <= 1'b0;
            r_pv  <= 1'b0;
        end else begin
            r_pv <= r_iss;
            if (o_take || (r_state == S_DECIDE && !r_req.lookup)) begin
                r_iss <= 1'b1;
            end else if (r_iss && r_cnt == LAST) begin
                r_iss <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt;
        if (o_take || (r_state == S_DECIDE && !r_req.lookup)) begin
            r_cnt <= '0;
        end else if (r_iss && r_cnt != LAST) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // scan: first valid match, lowest free slot, oldest entry after ageing
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_req        <= i_head.req;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_best       <= '0;
            r_best_idx   <= '0;
        end else if (r_state == S_SCAN && r_pv) begin
            if (w_hit_now && !r_found) begin
                r_found     <= 1'b1;
                r_match_idx <= r_pidx;
            end
            if (!w_valid_now && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_pidx;
            end
            if (w_aged > r_best) begin
                r_best     <= w_aged;
                r_best_idx <= r_pidx;
            end
        end
    end

    // choose the target slot
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            priority if (r_found) begin
                r_slot <= r_match_idx;
            end else if (r_free_found) begin
                r_slot <= r_free_idx;
            end else begin
                r_slot <= r_best_idx;
            end
        end
    end

    // age rewrite: chosen slot to zero, other valid entries one older, capped at AGE_MAX
    assign w_age_we    = (r_state == S_AGE) && r_pv &&
                         ((r_pidx == r_slot) || w_valid_now);
    assign w_age_wdata = (r_pidx == r_slot) ? '0 : w_aged;
    assign w_tab_we    = (r_state == S_AGE);

    // fill count, grows when the lowest free slot is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_tab_we && (AGE_W'(r_slot) == r_fill)) begin
            r_fill <= r_fill + AGE_W'(1);
        end
    end

    fst_ram #(.WIDTH(PAGE_W), .DEPTH(TABLE_ENTRIES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (r_slot),
        .i_wdata (r_req.page),
        .i_raddr (r_cnt),
        .o_rdata (w_page_rd)
    );

    fst_ram #(.WIDTH(DIST_W), .DEPTH(TABLE_ENTRIES)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (r_slot),
        .i_wdata (r_req.distance),
        .i_raddr (r_slot),
        .o_rdata (w_dist_rd)
    );

    fst_ram #(.WIDTH(AGE_W), .DEPTH(TABLE_ENTRIES)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (w_age_we),
        .i_waddr (r_pidx),
        .i_wdata (w_age_wdata),
        .i_raddr (r_cnt),
        .o_rdata (w_age_rd)
    );

    // result register, refilled only once the previous transfer has gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_RESULT && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && w_out_free) begin
            r_out_hit  <= r_found;
            r_out_dist <= r_found ? t_dist'(w_dist_rd) : '0;
        end
    end

    assign empty          = !r_out_vld;
    assign o_hit          = r_out_hit;
    assign o_distance_out = r_out_dist;

    // entries never drop out of the table
    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_fill >= $past(r_fill)))
        else $error("fill count went down");

    // the last swept entry always closes the sweep
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_eval |=> (r_state == S_DECIDE || r_state == S_IDLE))
        else $error("sweep did not finish after the last entry");

    // rewrite targets a slot inside the table
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AGE) |-> (r_slot <= LAST))
        else $error("target slot out of range");

endmodule

>>> hw/rtl/fifo_sampler_table.sv
// fifo_sampler_table: top level of the page to prefetch-distance table
// depends on fst_pkg, fst_front and fst_engine
//
// Usage: both sides look like a queue. A request is taken when push is high
// and full is low; it carries an action (insert or lookup), a 52-bit page
// number and a signed 8-bit distance. A lookup gives one result (hit and
// the stored distance, zero on a miss), taken when pop is high and empty is
// low. An insert gives no result.
// Every request sweeps all TABLE_ENTRIES entries one per cycle through the
// page and age memories. A lookup's result is registered after its match
// sweep and a read of the distance memory; an insert occupies the back end
// for a match sweep over the entries, then for an age rewrite sweep.
// A two-entry request queue keeps taking requests while the back end works.
// Reset clears the fill count, so the table starts empty with no clearing
// sweep; slots fill from the bottom and never empty. If the receiver
// stalls, the result waits in the output register and the back end holds
// the next lookup until it is taken.
module fifo_sampler_table import fst_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  logic  i_action,
    input  t_page i_page_number,
    input  t_dist i_distance_in,
    output logic  empty,
    input  logic  pop,
    output logic  o_hit,
    output t_dist o_distance_out
);

    t_req_q w_head;
    logic   w_take;

    // request side
    fst_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_page_number (i_page_number),
        .i_distance_in (i_distance_in),
        .o_head        (w_head),
        .i_take        (w_take)
    );

    // table and result side
    fst_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_take         (w_take),
        .empty          (empty),
        .pop            (pop),
        .o_hit          (o_hit),
        .o_distance_out (o_distance_out)
    );

endmodule
